### rtl/core/acc_pkg.sv
package acc_pkg;

   // request codes
   localparam logic [2:0] REQ_CONVERT    = 3'd0;
   localparam logic [2:0] REQ_CALIBRATE  = 3'd1;
   localparam logic [2:0] REQ_ADJUST     = 3'd2;
   localparam logic [2:0] REQ_WRITE_TRIM = 3'd3;
   localparam logic [2:0] REQ_READ_TRIM  = 3'd4;
   localparam logic [2:0] REQ_SET_COMP   = 3'd5;

   // result status codes
   typedef enum logic [2:0] {
      STATUS_OK,
      STATUS_BAD_CHANNEL,
      STATUS_NOT_CAL,
      STATUS_BAD_REQ,
      STATUS_EQUAL_RAWS
   } status_type;

   // fixed point constants
   localparam logic signed [31:0] ONE_Q8_24    = 32'sh0100_0000;
   localparam logic signed [15:0] TEMP_25_Q8_8 = 16'sd6400;

   // divider: 41-bit magnitude numerator, one quotient bit a cycle
   localparam int unsigned DIV_STEPS = 41;

   // one calibration table entry
   typedef struct packed {
      logic signed [31:0] slope;
      logic signed [31:0] offset;
      logic signed [31:0] trim;
      logic signed [15:0] base_temp;
      logic               calibrated;
      logic               mode;
      logic signed [31:0] slope_coeff;
      logic signed [31:0] offset_coeff;
   } entry_type;

   localparam entry_type RESET_ENTRY = '{
      slope:        ONE_Q8_24,
      offset:       32'sd0,
      trim:         32'sd0,
      base_temp:    TEMP_25_Q8_8,
      calibrated:   1'b0,
      mode:         1'b0,
      slope_coeff:  32'sd0,
      offset_coeff: 32'sd0
   };

endpackage

### rtl/core/adc_channel_calibration_unit.sv
// channel | ports                                   | direction
// req     | req_valid, req_stall, request fields    | in, stall out
// rsp     | rsp_valid, rsp_stall, status and value  | out, stall in
// csr     | csr_valid, csr_ready, csr_current_temp  | in, ready out
//
// One request is worked at a time. Convert and adjust pass through the
// compensation chain, trim and compensation requests go straight to the
// result, and a factory calibration uses the one-bit-a-cycle divider (41
// steps). The shared 33x33 multiplier is stepped over the compensation chain.
// Reset is synchronous; table entries read as their reset values until
// written, tracked by one valid bit per entry. A stalled result holds in the
// output register; the unit waits for it before loading the next word.
module adc_channel_calibration_unit #(
   parameter int SE_CHANNELS = 4,
   parameter int DI_CHANNELS = 2,
   parameter int RAW_BITS    = 24
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [2:0]                 req_type,
   input  logic                       req_channel_type,
   input  logic [2:0]                 req_channel_index,
   input  logic signed [RAW_BITS-1:0] req_raw_value,
   input  logic signed [RAW_BITS-1:0] req_raw_second,
   input  logic signed [31:0]         req_ref_value,
   input  logic signed [31:0]         req_ref_second,
   input  logic signed [15:0]         req_temperature,
   input  logic                       req_comp_mode,
   input  logic signed [31:0]         req_slope_coeff,
   input  logic signed [31:0]         req_offset_coeff,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [2:0]                 rsp_status,
   output logic signed [31:0]         rsp_value,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic signed [15:0]         csr_current_temp
);

   localparam int SLOTS  = SE_CHANNELS + DI_CHANNELS;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W  = $clog2(acc_pkg::DIV_STEPS);

   typedef enum logic [3:0] {
      S_IDLE, S_LOAD, S_REL, S_ES, S_COR, S_SUM,
      S_DIV, S_QUO, S_CMUL, S_CAL, S_OUT
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sd2147483647) r = 32'sh7FFF_FFFF;
      else if (v < -66'sd2147483648) r = 32'sh8000_0000;
      else r = v[31:0];
      return r;
   endfunction

   state_type                 state_ff;
   acc_pkg::status_type       status_ff;
   logic signed [31:0]        value_ff;
   logic                      rsp_valid_ff;
   logic [2:0]                rsp_status_ff;
   logic signed [31:0]        rsp_value_ff;
   logic signed [15:0]        current_temp_ff;
   logic [SLOTS-1:0]          valid_ff;
   acc_pkg::entry_type        mem [SLOTS];
   acc_pkg::entry_type        mem_q_ff;
   logic [SLOT_W-1:0]         slot_ff;
   logic [2:0]                type_ff;
   logic signed [RAW_BITS-1:0] raw1_ff;
   logic signed [RAW_BITS-1:0] raw2_ff;
   logic signed [31:0]        ref1_ff;
   logic signed [31:0]        ref2_ff;
   logic signed [15:0]        temp_ff;
   logic                      comp_mode_ff;
   logic signed [31:0]        slope_coeff_ff;
   logic signed [31:0]        offset_coeff_ff;
   logic signed [65:0]        mul_p_ff;
   logic signed [31:0]        es_ff;
   logic signed [40:0]        corr_ff;
   logic [40:0]               num_ff;
   logic [32:0]               den_ff;
   logic [32:0]               rem_ff;
   logic                      neg_ff;
   logic [CNT_W-1:0]          cnt_ff;

   acc_pkg::status_type       status_in;
   logic [SLOT_W-1:0]         slot_in;
   acc_pkg::entry_type        ent;
   acc_pkg::entry_type        mem_wd;
   logic                      mem_we;
   logic                      accept;
   logic signed [16:0]        dt;
   logic signed [32:0]        mul_a;
   logic signed [32:0]        mul_b;
   logic signed [65:0]        p_r8;
   logic signed [65:0]        p_r31;
   logic signed [32:0]        raw1_x;
   logic signed [32:0]        raw_diff;
   logic signed [32:0]        ref_diff;
   logic signed [40:0]        num_s;
   logic [40:0]               num_mag;
   logic [32:0]               den_mag;
   logic [33:0]               rem_sh;
   logic                      rem_ge;
   logic signed [31:0]        sl_calc;
   logic signed [31:0]        es_calc;
   logic signed [31:0]        conv_val;
   logic signed [31:0]        adj_val;
   logic signed [31:0]        cal_off;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_value  = rsp_value_ff;

   // request check and slot lookup
   always_comb begin
      status_in = acc_pkg::STATUS_OK;
      slot_in   = '0;
      if (req_type > acc_pkg::REQ_SET_COMP) begin
         status_in = acc_pkg::STATUS_BAD_REQ;
      end else if (!req_channel_type) begin
         if ({1'b0, req_channel_index} < 4'(SE_CHANNELS)) begin
            slot_in = SLOT_W'(req_channel_index);
         end else begin
            status_in = acc_pkg::STATUS_BAD_CHANNEL;
         end
      end else begin
         if ({1'b0, req_channel_index} < 4'(DI_CHANNELS)) begin
            slot_in = SLOT_W'(SE_CHANNELS) + SLOT_W'(req_channel_index);
         end else begin
            status_in = acc_pkg::STATUS_BAD_CHANNEL;
         end
      end
   end

   // entry seen by the datapath: unwritten entries read as reset
   assign ent = valid_ff[slot_ff] ? mem_q_ff : acc_pkg::RESET_ENTRY;
   assign dt  = 17'(current_temp_ff) - 17'($signed(ent.base_temp));
   assign raw1_x = 33'(raw1_ff);

   // rounded shifts of the product
   assign p_r8  = (mul_p_ff + 66'sd128) >>> 8;
   assign p_r31 = (mul_p_ff + 66'sd1073741824) >>> 31;

   // divider setup and step
   assign raw_diff = 33'(raw2_ff) - 33'(raw1_ff);
   assign ref_diff = 33'(ref2_ff) - 33'(ref1_ff);
   assign num_s    = {ref_diff, 8'b0};
   assign den_mag  = raw_diff[32] ? 33'(-raw_diff) : 33'(raw_diff);
   assign num_mag  = (num_s[40] ? 41'(-num_s) : 41'(num_s)) + 41'(den_mag >> 1);
   assign rem_sh   = {rem_ff, num_ff[40]};
   assign rem_ge   = rem_sh >= {1'b0, den_ff};

   // quotient sign and saturation
   always_comb begin
      if (!neg_ff) begin
         sl_calc = (num_ff > 41'd2147483647) ? 32'sh7FFF_FFFF : num_ff[31:0];
      end else begin
         sl_calc = (num_ff > 41'd2147483648) ? 32'sh8000_0000 : -num_ff[31:0];
      end
   end

   // result arithmetic
   assign es_calc  = sat32(66'($signed(ent.slope)) + (ent.mode ? p_r8 : 66'sd0));
   assign conv_val = sat32(p_r8 + 66'($signed(ent.offset)) + 66'($signed(ent.trim))
                           + 66'(corr_ff));
   assign adj_val  = sat32(66'(ref1_ff) - p_r8 - 66'(corr_ff));
   assign cal_off  = sat32(66'(ref1_ff) - p_r8);

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_LOAD: begin
            mul_a = 33'($signed(ent.slope));
            mul_b = 33'($signed(ent.slope_coeff));
         end
         S_REL: begin
            mul_a = p_r31[32:0];
            mul_b = 33'(dt);
         end
         S_ES: begin
            mul_a = 33'($signed(ent.offset_coeff));
            mul_b = 33'(dt);
         end
         S_COR, S_CMUL: begin
            mul_a = 33'(es_ff);
            mul_b = raw1_x;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // table write back
   always_comb begin
      mem_we = 1'b0;
      mem_wd = ent;
      case (state_ff)
         S_LOAD: begin
            if (status_ff == acc_pkg::STATUS_OK) begin
               if (type_ff == acc_pkg::REQ_WRITE_TRIM) begin
                  mem_we      = 1'b1;
                  mem_wd.trim = ref1_ff;
               end else if (type_ff == acc_pkg::REQ_SET_COMP) begin
                  mem_we              = 1'b1;
                  mem_wd.mode         = comp_mode_ff;
                  mem_wd.slope_coeff  = slope_coeff_ff;
                  mem_wd.offset_coeff = offset_coeff_ff;
               end
            end
         end
         S_SUM: begin
            if (type_ff == acc_pkg::REQ_ADJUST) begin
               mem_we        = 1'b1;
               mem_wd.offset = adj_val;
            end
         end
         S_CAL: begin
            mem_we              = 1'b1;
            mem_wd.slope        = es_ff;
            mem_wd.offset       = cal_off;
            mem_wd.trim         = 32'sd0;
            mem_wd.base_temp    = temp_ff;
            mem_wd.slope_coeff  = 32'sd0;
            mem_wd.offset_coeff = 32'sd0;
            mem_wd.calibrated   = 1'b1;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // calibration table memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[slot_ff] <= mem_wd;
      end
      if (accept) begin
         mem_q_ff <= mem[slot_in];
      end
   end

   // sequencer, datapath and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         rsp_valid_ff    <= 1'b0;
         valid_ff        <= '0;
         current_temp_ff <= acc_pkg::TEMP_25_Q8_8;
      end else begin
         if (csr_valid && csr_ready) begin
            current_temp_ff <= csr_current_temp;
         end
         // result taken with no new word behind it
         if (rsp_valid_ff && !rsp_stall && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         if (mem_we) begin
            valid_ff[slot_ff] <= 1'b1;
         end
         mul_p_ff <= mul_a * mul_b;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  status_ff       <= status_in;
                  slot_ff         <= slot_in;
                  type_ff         <= req_type;
                  raw1_ff         <= req_raw_value;
                  raw2_ff         <= req_raw_second;
                  ref1_ff         <= req_ref_value;
                  ref2_ff         <= req_ref_second;
                  temp_ff         <= req_temperature;
                  comp_mode_ff    <= req_comp_mode;
                  slope_coeff_ff  <= req_slope_coeff;
                  offset_coeff_ff <= req_offset_coeff;
                  value_ff        <= 32'sd0;
                  state_ff        <= S_LOAD;
               end
            end
            S_LOAD: begin
               if (status_ff == acc_pkg::STATUS_OK) begin
                  case (type_ff)
                     acc_pkg::REQ_CONVERT, acc_pkg::REQ_ADJUST: begin
                        if (!ent.calibrated) begin
                           status_ff <= acc_pkg::STATUS_NOT_CAL;
                           state_ff  <= S_OUT;
                        end else begin
                           state_ff <= S_REL;
                        end
                     end
                     acc_pkg::REQ_CALIBRATE: begin
                        if (raw1_ff == raw2_ff) begin
                           status_ff <= acc_pkg::STATUS_EQUAL_RAWS;
                           state_ff  <= S_OUT;
                        end else begin
                           num_ff   <= num_mag;
                           den_ff   <= den_mag;
                           rem_ff   <= '0;
                           neg_ff   <= num_s[40] ^ raw_diff[32];
                           cnt_ff   <= CNT_W'(acc_pkg::DIV_STEPS - 1);
                           state_ff <= S_DIV;
                        end
                     end
                     acc_pkg::REQ_READ_TRIM: begin
                        value_ff <= ent.trim;
                        state_ff <= S_OUT;
                     end
                     default: begin
                        state_ff <= S_OUT;
                     end
                  endcase
               end else begin
                  state_ff <= S_OUT;
               end
            end
            S_REL: begin
               state_ff <= S_ES;
            end
            S_ES: begin
               es_ff    <= es_calc;
               state_ff <= S_COR;
            end
            S_COR: begin
               corr_ff  <= ent.mode ? p_r8[40:0] : 41'sd0;
               state_ff <= S_SUM;
            end
            S_SUM: begin
               value_ff <= (type_ff == acc_pkg::REQ_ADJUST) ? adj_val : conv_val;
               state_ff <= S_OUT;
            end
            S_DIV: begin
               rem_ff <= rem_ge ? 33'(rem_sh - {1'b0, den_ff}) : rem_sh[32:0];
               num_ff <= {num_ff[39:0], rem_ge};
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  state_ff <= S_QUO;
               end
            end
            S_QUO: begin
               es_ff    <= sl_calc;
               state_ff <= S_CMUL;
            end
            S_CMUL: begin
               state_ff <= S_CAL;
            end
            S_CAL: begin
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= status_ff;
                  rsp_value_ff  <= value_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule
